// ===== design/bdch_pkg.sv =====
`timescale 1ns / 1ps

package bdch_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam int NOW_W   = 32;
  localparam int MS_W    = 16;
  localparam int COUNT_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [MS_W-1:0] DEBOUNCE_MS_RST = 16'd50;
  localparam logic [MS_W-1:0] HOLD_MS_RST     = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_MS     = 2'd0,
    REG_HOLD_TIMEOUT_MS = 2'd1,
    REG_INVERT_POLARITY = 2'd2,
    REG_PULL_TYPE       = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_PIN      = 1'b0,
    MODE_EXTERNAL = 1'b1
  } level_mode_t;

endpackage

// ===== design/button_debounce_click_hold.sv =====
`timescale 1ns / 1ps

// An accepted item passes from the input register to the result register (out_valid
// high from then) once the output is not stalled; from there it can be taken.
// Throughput: one item per cycle while out_ready holds; input and result registers part
// the sides, with the timer compare and flag update for one poll between them.
// Reset (rst, synchronous, active high): debounce 50 ms, hold 500 ms, polarity and
// pull cleared, all press/hold/click state and counters zero, no item held.
module button_debounce_click_hold
  import bdch_pkg::*;
#(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic                 raw_level,
  input  logic [NOW_W-1:0]     now_ms,
  input  logic                 clear_events,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 press_event,
  output logic                 release_event,
  output logic                 click_event,
  output logic                 hold_event,
  output logic                 holding,
  output logic [COUNT_W-1:0]   click_count,
  output logic [COUNT_W-1:0]   clicks_before_hold
);

  // configuration
  logic [MS_W-1:0] debounce_ms;
  logic [MS_W-1:0] hold_timeout_ms;
  logic            invert_polarity;
  logic            pull_type;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DEBOUNCE_MS_RST;
      hold_timeout_ms <= HOLD_MS_RST;
      invert_polarity <= 1'b0;
      pull_type       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE_MS:     debounce_ms     <= cfg_data;
        REG_HOLD_TIMEOUT_MS: hold_timeout_ms <= cfg_data;
        REG_INVERT_POLARITY: invert_polarity <= cfg_data[0];
        REG_PULL_TYPE:       pull_type       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  logic                  s1_valid;
  level_mode_t           s1_mode;
  logic                  s1_level;
  logic [TIME_WIDTH-1:0] s1_now;
  logic                  s1_clear;
  logic                  advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode  <= level_mode_t'(mode);
      s1_level <= raw_level;
      s1_now   <= TIME_WIDTH'(now_ms);
      s1_clear <= clear_events;
    end
  end

  // button state
  logic                   pressed, debouncing, hold_reached, step_active, click_pending;
  logic [TIME_WIDTH-1:0]  mark_time;
  logic [COUNT_WIDTH-1:0] clicks, hold_clicks;

  logic                   pressed_next, debouncing_next, hold_reached_next;
  logic                   step_active_next, click_pending_next;
  logic [TIME_WIDTH-1:0]  mark_time_next;
  logic [COUNT_WIDTH-1:0] clicks_next, hold_clicks_next;
  logic                   ev_press, ev_rel, ev_click, ev_hold;

  logic                  down;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  debounce_done, hold_done;

  always_comb begin
    unique case (s1_mode)
      MODE_EXTERNAL: down = s1_level ^ invert_polarity;
      MODE_PIN:      down = !s1_level ^ invert_polarity ^ pull_type;
      default:       down = 1'b0;
    endcase
  end

  assign elapsed       = s1_now - mark_time;
  assign debounce_done = elapsed >= TIME_WIDTH'(debounce_ms);
  assign hold_done     = elapsed >= TIME_WIDTH'(hold_timeout_ms);

  always_comb begin
    pressed_next       = pressed;
    debouncing_next    = debouncing;
    hold_reached_next  = hold_reached;
    step_active_next   = s1_clear ? 1'b0 : step_active;
    click_pending_next = click_pending;
    mark_time_next     = mark_time;
    clicks_next        = clicks;
    hold_clicks_next   = s1_clear ? '0 : hold_clicks;
    ev_press = 1'b0;
    ev_rel   = 1'b0;
    ev_click = 1'b0;
    ev_hold  = 1'b0;

    if (down && !pressed) begin
      if (!debouncing) begin
        debouncing_next = 1'b1;
        mark_time_next  = s1_now;
      end else if (debounce_done) begin
        pressed_next       = 1'b1;
        ev_press           = 1'b1;
        click_pending_next = 1'b1;
      end
    end else begin
      debouncing_next = 1'b0;
    end

    if (!down && pressed) begin
      pressed_next = 1'b0;
      if (!hold_reached) begin
        clicks_next = clicks + COUNT_WIDTH'(1);
      end
      hold_reached_next = 1'b0;
      ev_rel            = 1'b1;
      mark_time_next    = s1_now;
      if (step_active_next) begin
        clicks_next      = '0;
        step_active_next = 1'b0;
      end
      if (click_pending) begin
        click_pending_next = 1'b0;
        ev_click           = 1'b1;
      end
    end

    // mark_time is untouched above whenever this can fire
    if (pressed_next && down && !hold_reached && hold_done) begin
      hold_reached_next  = 1'b1;
      hold_clicks_next   = clicks_next;
      ev_hold            = 1'b1;
      step_active_next   = 1'b1;
      click_pending_next = 1'b0;
      mark_time_next     = s1_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed       <= 1'b0;
      debouncing    <= 1'b0;
      hold_reached  <= 1'b0;
      step_active   <= 1'b0;
      click_pending <= 1'b0;
      mark_time     <= '0;
      clicks        <= '0;
      hold_clicks   <= '0;
    end else if (advance) begin
      pressed       <= pressed_next;
      debouncing    <= debouncing_next;
      hold_reached  <= hold_reached_next;
      step_active   <= step_active_next;
      click_pending <= click_pending_next;
      mark_time     <= mark_time_next;
      clicks        <= clicks_next;
      hold_clicks   <= hold_clicks_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      press_event        <= ev_press;
      release_event      <= ev_rel;
      click_event        <= ev_click;
      hold_event         <= ev_hold;
      holding            <= step_active_next;
      click_count        <= COUNT_W'(clicks_next);
      clicks_before_hold <= COUNT_W'(hold_clicks_next);
    end
  end

  a_hold_sets_holding: assert property (@(posedge clk) disable iff (rst)
    out_valid && hold_event |-> holding)
    else $error("hold event without holding level");

  a_press_release_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(press_event && release_event))
    else $error("press and release in one item");

  a_click_needs_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && click_event |-> release_event)
    else $error("click without release");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

endmodule
